FILE: rtl/twhc_pkg.sv
// Shared types and constants for the text wrap height counter.
`default_nettype none

package twhc_pkg;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_CHAR = 2'd1,
    OP_END  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_WRAP_WIDTH    = 3'd0,
    REG_LINE_HEIGHT   = 3'd1,
    REG_GLYPH_COUNT   = 3'd2,
    REG_SPACE_ADVANCE = 3'd3,
    REG_TAB_ADVANCE   = 3'd4
  } reg_e;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [15:0] HEIGHT_MAX = 16'hFFFF;
  localparam logic [8:0]  GLYPH_COUNT_RST = 9'd256;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [7:0] glyph_advance;
  } in_item_t;

  typedef struct packed {
    logic [15:0] text_height;
    logic        string_done;
  } out_item_t;

  typedef struct packed {
    logic [15:0] wrap_width;
    logic [7:0]  line_height;
    logic [8:0]  glyph_count;
    logic [7:0]  space_advance;
    logic [9:0]  tab_advance;
  } cfg_t;

  // Item held in the second stage while the table read completes.
  typedef struct packed {
    logic       valid;
    logic [1:0] operation;
    logic [7:0] char_code;
  } stage_t;

endpackage

`default_nettype wire

FILE: rtl/text_wrap_height_counter.sv
// Top level of the greedy word-wrap text height counter.
// Usage:
//  - Input channel (in_valid_i/in_ready_o, in_item_i): one item per
//    handshake. A load item writes a glyph width into the advance table,
//    a character item advances the layout, an end item closes the string.
//  - Output channel (out_valid_o/out_ready_i, out_item_o): exactly one
//    result item per input item, in order. Running results carry
//    string_done low; the result of an end item carries it high and the
//    running layout state is then cleared (the table and registers stay).
//  - Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i;
//    write only while no item is in flight.
//  - Order: the accepting edge issues the table read and loads stage two;
//    stage two then takes the read data, updates pen, word and height
//    and loads the output register once that register is free.
//  - Throughput: one item per cycle while results are taken; the table has
//    one read and one write port and the layout update is combinational.
//  - Stall: if the result is not taken, the second stage holds, and the
//    input is still taken while that stage is empty.
//  - Reset: layout state cleared, registers to defaults, table reads zero.
`default_nettype none

module text_wrap_height_counter #(
  parameter int unsigned GLYPHS    = 256,
  parameter int unsigned SPAN_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire twhc_pkg::in_item_t                  in_item_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output twhc_pkg::out_item_t                      out_item_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [2:0]                          cfg_idx_i,
  input  wire logic [twhc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned AW = $clog2(GLYPHS);
  localparam logic [8:0] GLYPHS_W = 9'(GLYPHS);

  twhc_pkg::cfg_t      cfg_q;
  twhc_pkg::stage_t    stage_q;
  twhc_pkg::out_item_t out_q, result;
  logic                out_valid_q;
  logic                accept, step, in_range;
  logic [7:0]          glyph_w;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wrap_width    <= '0;
      cfg_q.line_height   <= '0;
      cfg_q.glyph_count   <= twhc_pkg::GLYPH_COUNT_RST;
      cfg_q.space_advance <= '0;
      cfg_q.tab_advance   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        twhc_pkg::REG_WRAP_WIDTH:    cfg_q.wrap_width    <= cfg_data_i;
        twhc_pkg::REG_LINE_HEIGHT:   cfg_q.line_height   <= cfg_data_i[7:0];
        twhc_pkg::REG_GLYPH_COUNT:   cfg_q.glyph_count   <= cfg_data_i[8:0];
        twhc_pkg::REG_SPACE_ADVANCE: cfg_q.space_advance <= cfg_data_i[7:0];
        twhc_pkg::REG_TAB_ADVANCE:   cfg_q.tab_advance   <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Second stage moves on when the output register is free or draining.
  assign step       = stage_q.valid && (!out_valid_q || out_ready_i);
  assign in_ready_o = !stage_q.valid || step;
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = 9'(in_item_i.char_code) < GLYPHS_W;

  twhc_glyph_mem #(
    .GLYPHS (GLYPHS)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (accept && in_range && (in_item_i.operation == twhc_pkg::OP_LOAD)),
    .waddr_i (in_item_i.char_code[AW-1:0]),
    .wdata_i (in_item_i.glyph_advance),
    .re_i    (accept && in_range && (in_item_i.operation == twhc_pkg::OP_CHAR)),
    .raddr_i (in_item_i.char_code[AW-1:0]),
    .rdata_o (glyph_w)
  );

  twhc_wrap_core #(
    .GLYPHS    (GLYPHS),
    .SPAN_BITS (SPAN_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .stage_i  (stage_q),
    .cw_i     (glyph_w),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        stage_q.valid     <= 1'b1;
        stage_q.operation <= in_item_i.operation;
        stage_q.char_code <= in_item_i.char_code;
      end else if (step) begin
        stage_q.valid <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/twhc_glyph_mem.sv
// Glyph advance memory with per-entry valid bits and registered read.
`default_nettype none

module twhc_glyph_mem #(
  parameter int unsigned GLYPHS = 256
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      we_i,
  input  wire logic [$clog2(GLYPHS)-1:0] waddr_i,
  input  wire logic [7:0]                wdata_i,
  input  wire logic                      re_i,
  input  wire logic [$clog2(GLYPHS)-1:0] raddr_i,
  output logic [7:0]                     rdata_o
);

  logic [7:0]        mem [GLYPHS];
  logic [GLYPHS-1:0] valid_q;
  logic [7:0]        rdata_q;
  logic              rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // Entries never written read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : 8'd0;

endmodule

`default_nettype wire

FILE: rtl/twhc_wrap_core.sv
// Line layout state and per-character wrap decision.
`default_nettype none

module twhc_wrap_core #(
  parameter int unsigned GLYPHS    = 256,
  parameter int unsigned SPAN_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire twhc_pkg::stage_t   stage_i,
  input  wire logic [7:0]         cw_i,
  input  wire twhc_pkg::cfg_t     cfg_i,
  output twhc_pkg::out_item_t     result_o
);

  localparam int unsigned XW = (SPAN_BITS + 2 > 17) ? SPAN_BITS + 2 : 17;
  localparam logic [SPAN_BITS-1:0] SPAN_MAX = {SPAN_BITS{1'b1}};
  localparam logic [8:0] GLYPHS_W = 9'(GLYPHS);

  logic [SPAN_BITS-1:0] pen_q, pen_d, word_q, word_d;
  logic [15:0]          height_q, height_d, height_mid;
  logic [XW-1:0]        pen_x, word_x, wrap_x, sep_x, cw_x;
  logic [XW-1:0]        line_sum, sep_sum, cw_sum, word_sep, word_cw;
  logic [16:0]          h_add, h_out;
  logic                 skip, is_char, is_end;

  function automatic logic [SPAN_BITS-1:0] sat_span(input logic [XW-1:0] v);
    sat_span = (v > XW'(SPAN_MAX)) ? SPAN_MAX : v[SPAN_BITS-1:0];
  endfunction

  always_comb begin
    pen_x    = XW'(pen_q);
    word_x   = XW'(word_q);
    wrap_x   = XW'(cfg_i.wrap_width);
    cw_x     = XW'(cw_i);
    sep_x    = (stage_i.char_code == twhc_pkg::CH_TAB) ? XW'(cfg_i.tab_advance)
                                                       : XW'(cfg_i.space_advance);
    line_sum = pen_x + word_x;
    sep_sum  = line_sum + sep_x;
    cw_sum   = line_sum + cw_x;
    word_sep = word_x + sep_x;
    word_cw  = word_x + cw_x;
    h_add    = 17'(height_q) + 17'(cfg_i.line_height);

    is_char = stage_i.operation == twhc_pkg::OP_CHAR;
    is_end  = stage_i.operation == twhc_pkg::OP_END;
    skip    = (9'(stage_i.char_code) >= cfg_i.glyph_count)
           || (9'(stage_i.char_code) >= GLYPHS_W)
           || (cfg_i.wrap_width == 16'd0);

    pen_d      = pen_q;
    word_d     = word_q;
    height_mid = height_q;

    if (is_char && !skip) begin
      if (stage_i.char_code == twhc_pkg::CH_SPACE ||
          stage_i.char_code == twhc_pkg::CH_TAB) begin
        if (sep_sum > wrap_x) begin
          pen_d      = sat_span(word_sep);
          height_mid = h_add[16] ? twhc_pkg::HEIGHT_MAX : h_add[15:0];
        end else begin
          pen_d = sat_span(sep_sum);
        end
        word_d = '0;
      end else if (stage_i.char_code == twhc_pkg::CH_NEWLINE) begin
        pen_d      = '0;
        word_d     = '0;
        height_mid = h_add[16] ? twhc_pkg::HEIGHT_MAX : h_add[15:0];
      end else if (word_cw > wrap_x && pen_q == '0) begin
        // Word longer than the line: split it here.
        height_mid = h_add[16] ? twhc_pkg::HEIGHT_MAX : h_add[15:0];
        word_d     = sat_span(cw_x);
      end else if (cw_sum > wrap_x) begin
        pen_d      = '0;
        height_mid = h_add[16] ? twhc_pkg::HEIGHT_MAX : h_add[15:0];
        word_d     = sat_span(word_cw);
      end else begin
        word_d = sat_span(word_cw);
      end
    end

    h_out = 17'(height_mid) + 17'(cfg_i.line_height);
    if (cfg_i.wrap_width == 16'd0) begin
      result_o.text_height = 16'(cfg_i.line_height);
    end else begin
      result_o.text_height = h_out[16] ? twhc_pkg::HEIGHT_MAX : h_out[15:0];
    end
    result_o.string_done = is_end;

    height_d = height_mid;
    if (is_end) begin
      pen_d    = '0;
      word_d   = '0;
      height_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q    <= '0;
      word_q   <= '0;
      height_q <= '0;
    end else if (step_i) begin
      pen_q    <= pen_d;
      word_q   <= word_d;
      height_q <= height_d;
    end
  end

endmodule

`default_nettype wire
